>>> rtl/gsc_pkg.sv
// ----------------------------------------------------------------------------
// gsc_pkg: shared types and constants of the gas sensor compensation block
// Field widths, register indexes, status codes, the two compensation curves
// and the structs that pass configuration and numerator data between units.
// ----------------------------------------------------------------------------
package gsc_pkg;

	localparam int VOLT_W = 23;
	localparam int TEMP_W = 12;
	localparam int PPB_W = 24;
	localparam int STATUS_W = 2;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int SENS_W = 15;

	localparam int A_W = 28;
	localparam int B_W = 27;
	localparam int FACTOR_W = 13;
	localparam int NUM_W = 40;
	localparam int MAG_W = NUM_W - 1;
	localparam int DIV_W = 25;

	localparam int DIV_STAGES = 8;
	localparam int BITS_PER_STAGE = 3;
	localparam int QUO_W = DIV_STAGES * BITS_PER_STAGE;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FORMULA_SELECT = 3'd0,
		CFG_WORKER_EZERO   = 3'd1,
		CFG_AUX_EZERO      = 3'd2,
		CFG_WORKER_TZERO   = 3'd3,
		CFG_AUX_TZERO      = 3'd4,
		CFG_SENSITIVITY    = 3'd5
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK     = 2'd0,
		STATUS_SAT    = 2'd1,
		STATUS_NOSENS = 2'd2
	} status_t;

	// Offsets and divisor already scaled to microvolts / thousandths.
	typedef struct packed {
		logic                  fsel;
		logic                  sens_zero;
		logic signed [A_W-1:0] a_off;
		logic signed [B_W-1:0] b_off;
		logic [DIV_W-1:0]      divisor;
	} cfg_t;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} num_t;

	typedef struct packed {
		logic             neg;
		logic             ovf;
		logic [QUO_W-1:0] quo;
	} quo_t;

	// Compensation curves in tenths, points at -30..50 C in 10 C steps.
	// sel = 1 picks curve three, sel = 0 curve one.
	function automatic logic signed [6:0] curve_point(input logic sel,
		input logic [3:0] idx);
		logic signed [6:0] k;
		case (idx)
			4'd0, 4'd1, 4'd2, 4'd3: k = sel ? 7'sd10 : 7'sd13;
			4'd4: k = 7'sd10;
			4'd5: k = sel ? 7'sd10 : 7'sd6;
			4'd6: k = 7'sd4;
			4'd7: k = sel ? -7'sd1 : 7'sd2;
			default: k = sel ? -7'sd40 : -7'sd15;
		endcase
		return k;
	endfunction

endpackage

>>> rtl/gas_sensor_temp_compensated_ppb.sv
// ----------------------------------------------------------------------------
// gas_sensor_temp_compensated_ppb: temperature-compensated gas reading in ppb
// Corrects worker and auxiliary electrode voltages for their zero offsets,
// interpolates a temperature compensation factor and divides by the
// sensitivity, giving a saturated concentration with a status code.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  worker, aux, temperature
// m_axis    out        m_axis_tvalid/m_axis_tready  concentration, status
// cfg       in         cfg_valid/cfg_ready          register index, data
//
// One item per cycle sustained while the receiver takes results; a result
// passes fourteen registers in line: five front stages, eight divider
// stages of three quotient bits each, and the output register.
// Reset clears every valid bit and loads the register reset values; the
// scaled configuration follows a write in the next cycle.
// Each stage holds while its successor is stalled and fills any bubble, so
// input is still taken while a result waits at the output and a bubble remains.
// ----------------------------------------------------------------------------
module gas_sensor_temp_compensated_ppb (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [22:0] worker_microvolts, [45:23] aux_microvolts,
	// [57:46] temperature_tenths, [63:58] zero
	input  logic [63:0]                          s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [23:0] concentration_ppb
	output logic [gsc_pkg::PPB_W-1:0]            m_axis_tdata,
	// [1:0] result_status
	output logic [gsc_pkg::STATUS_W-1:0]         m_axis_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gsc_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [gsc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int VW = gsc_pkg::VOLT_W;
	localparam int TW = gsc_pkg::TEMP_W;
	localparam int PW = gsc_pkg::PPB_W;

	gsc_pkg::cfg_t  cfg;
	gsc_pkg::num_t  num;
	gsc_pkg::quo_t  quo;
	logic           num_valid, num_ready;
	logic           quo_valid, quo_ready;

	logic                 valid_q;
	logic [PW-1:0]        ppb_q;
	gsc_pkg::status_t     status_q;
	logic                 adv_out;
	logic                 sat_pos, sat_neg;

	gsc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gsc_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg),
		.in_valid           (s_axis_tvalid),
		.in_ready           (s_axis_tready),
		.worker_microvolts  (s_axis_tdata[VW-1:0]),
		.aux_microvolts     (s_axis_tdata[2*VW-1:VW]),
		.temperature_tenths ($signed(s_axis_tdata[2*VW+TW-1:2*VW])),
		.out_valid          (num_valid),
		.out_ready          (num_ready),
		.out_num            (num)
	);

	gsc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.divisor   (cfg.divisor),
		.in_valid  (num_valid),
		.in_ready  (num_ready),
		.in_num    (num),
		.out_valid (quo_valid),
		.out_ready (quo_ready),
		.out_quo   (quo)
	);

	// Output register: take a new result when empty or when the current one
	// leaves in this cycle.
	assign adv_out   = !valid_q || m_axis_tready;
	assign quo_ready = adv_out;

	// Saturate: a positive magnitude must stay below 2^23, a negative one
	// may reach exactly 2^23.
	assign sat_pos = !quo.neg && (quo.ovf || quo.quo[PW-1]);
	assign sat_neg = quo.neg && (quo.ovf || (quo.quo > {1'b1, {(PW-1){1'b0}}}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv_out) begin
			valid_q <= quo_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			if (cfg.sens_zero) begin
				ppb_q    <= '0;
				status_q <= gsc_pkg::STATUS_NOSENS;
			end else if (sat_pos) begin
				ppb_q    <= {1'b0, {(PW-1){1'b1}}};
				status_q <= gsc_pkg::STATUS_SAT;
			end else if (sat_neg) begin
				ppb_q    <= {1'b1, {(PW-1){1'b0}}};
				status_q <= gsc_pkg::STATUS_SAT;
			end else begin
				ppb_q    <= quo.neg ? PW'(-quo.quo) : quo.quo;
				status_q <= gsc_pkg::STATUS_OK;
			end
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = ppb_q;
	assign m_axis_tuser  = status_q;

endmodule

>>> rtl/gsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// gsc_cfg_regs: configuration register file
// Holds the six programmable registers and registers the scaled offsets,
// divisor and flags that the datapath uses.
// ----------------------------------------------------------------------------
module gsc_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [gsc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output gsc_pkg::cfg_t                     cfg
);

	logic                             fsel_q;
	logic signed [15:0]               wez_q;
	logic signed [15:0]               aez_q;
	logic signed [15:0]               wtz_q;
	logic signed [15:0]               atz_q;
	logic [gsc_pkg::SENS_W-1:0]       sens_q;
	logic signed [17:0]               zsum;
	gsc_pkg::cfg_t                    cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsel_q <= 1'b1;
			wez_q  <= '0;
			aez_q  <= '0;
			wtz_q  <= '0;
			atz_q  <= '0;
			sens_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				gsc_pkg::CFG_FORMULA_SELECT: fsel_q <= cfg_data[0];
				gsc_pkg::CFG_WORKER_EZERO:   wez_q  <= $signed(cfg_data);
				gsc_pkg::CFG_AUX_EZERO:      aez_q  <= $signed(cfg_data);
				gsc_pkg::CFG_WORKER_TZERO:   wtz_q  <= $signed(cfg_data);
				gsc_pkg::CFG_AUX_TZERO:      atz_q  <= $signed(cfg_data);
				gsc_pkg::CFG_SENSITIVITY:    sens_q <= cfg_data[gsc_pkg::SENS_W-1:0];
				default: ;
			endcase
		end
	end

	// Formula three folds to worker - 1000*(wtz - atz + aez).
	always_comb begin
		if (fsel_q) begin
			zsum = 18'(wtz_q) - 18'(atz_q) + 18'(aez_q);
		end else begin
			zsum = 18'(wez_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fsel      <= 1'b1;
			cfg_q.sens_zero <= 1'b1;
			cfg_q.a_off     <= '0;
			cfg_q.b_off     <= '0;
			cfg_q.divisor   <= '0;
		end else begin
			cfg_q.fsel      <= fsel_q;
			cfg_q.sens_zero <= (sens_q == '0);
			cfg_q.a_off     <= gsc_pkg::A_W'(zsum) * gsc_pkg::A_W'(1000);
			cfg_q.b_off     <= gsc_pkg::B_W'(aez_q) * gsc_pkg::B_W'(1000);
			cfg_q.divisor   <= gsc_pkg::DIV_W'(sens_q) * gsc_pkg::DIV_W'(1000);
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/gsc_front.sv
// ----------------------------------------------------------------------------
// gsc_front: compensation factor and numerator pipeline
// Five stages: offsets and segment, factor, products, numerator, magnitude.
// ----------------------------------------------------------------------------
module gsc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gsc_pkg::cfg_t                       cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [gsc_pkg::VOLT_W-1:0]          worker_microvolts,
	input  logic [gsc_pkg::VOLT_W-1:0]          aux_microvolts,
	input  logic signed [gsc_pkg::TEMP_W-1:0]   temperature_tenths,
	output logic                                out_valid,
	input  logic                                out_ready,
	output gsc_pkg::num_t                       out_num
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv1, adv2, adv3, adv4, adv5;

	logic signed [gsc_pkg::A_W-1:0]      a_s1, a_s2;
	logic signed [gsc_pkg::B_W-1:0]      b_s1, b_s2;
	logic                                cold_s1, hot_s1;
	logic [2:0]                          seg_s1;
	logic [6:0]                          d_s1;
	logic signed [gsc_pkg::FACTOR_W-1:0] factor_s2;
	logic signed [gsc_pkg::NUM_W-1:0]    prod_s3, a1000_s3, num_s4;
	gsc_pkg::num_t                       num_s5;

	logic signed [12:0]                  off_w;
	logic [9:0]                          off10;
	logic [2:0]                          seg_w;
	logic signed [gsc_pkg::FACTOR_W-1:0] factor_w;

	// Segment index of a distance of 0..799 tenths above -30 C.
	function automatic logic [2:0] seg_of(input logic [9:0] off);
		logic [2:0] s;
		s = '0;
		for (int i = 1; i < 8; i++) begin
			if (off >= 10'(i * 100)) begin
				s = 3'(i);
			end
		end
		return s;
	endfunction

	// Stall chain: a stage advances when empty or when its successor advances.
	assign adv5 = !v_s5 || out_ready;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end

	always_comb begin
		off_w = 13'(temperature_tenths) + 13'sd300;
		off10 = off_w[9:0];
		seg_w = seg_of(off10);
	end

	always_comb begin
		logic signed [6:0]  k_lo, k_hi;
		logic signed [7:0]  diff;
		k_lo = gsc_pkg::curve_point(cfg.fsel, {1'b0, seg_s1});
		k_hi = gsc_pkg::curve_point(cfg.fsel, {1'b0, seg_s1} + 4'd1);
		diff = 8'(k_hi) - 8'(k_lo);
		if (cold_s1) begin
			factor_w = gsc_pkg::FACTOR_W'(gsc_pkg::curve_point(cfg.fsel, 4'd0))
				* gsc_pkg::FACTOR_W'(100);
		end else if (hot_s1) begin
			factor_w = gsc_pkg::FACTOR_W'(gsc_pkg::curve_point(cfg.fsel, 4'd8))
				* gsc_pkg::FACTOR_W'(100);
		end else begin
			factor_w = gsc_pkg::FACTOR_W'(k_lo) * gsc_pkg::FACTOR_W'(100)
				+ $signed({6'b0, d_s1}) * gsc_pkg::FACTOR_W'(diff);
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			a_s1    <= $signed({5'b0, worker_microvolts}) - cfg.a_off;
			b_s1    <= $signed({4'b0, aux_microvolts}) - cfg.b_off;
			cold_s1 <= (temperature_tenths <= -12'sd300);
			hot_s1  <= (temperature_tenths >= 12'sd500);
			seg_s1  <= seg_w;
			d_s1    <= 7'(off10 - 10'(seg_w) * 10'd100);
		end
		if (adv2) begin
			factor_s2 <= factor_w;
			a_s2      <= a_s1;
			b_s2      <= b_s1;
		end
		if (adv3) begin
			prod_s3  <= gsc_pkg::NUM_W'(factor_s2) * gsc_pkg::NUM_W'(b_s2);
			a1000_s3 <= gsc_pkg::NUM_W'(a_s2) * gsc_pkg::NUM_W'(1000);
		end
		if (adv4) begin
			num_s4 <= a1000_s3 - prod_s3;
		end
		if (adv5) begin
			num_s5.neg <= num_s4[gsc_pkg::NUM_W-1];
			num_s5.mag <= num_s4[gsc_pkg::NUM_W-1] ? gsc_pkg::MAG_W'(-num_s4)
				: num_s4[gsc_pkg::MAG_W-1:0];
		end
	end

	assign out_valid = v_s5;
	assign out_num   = num_s5;

endmodule

>>> rtl/gsc_div.sv
// ----------------------------------------------------------------------------
// gsc_div: pipelined restoring divider
// Divides the numerator magnitude by 1000*sensitivity, three quotient bits
// per stage; flags quotients that do not fit the result width.
// ----------------------------------------------------------------------------
module gsc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [gsc_pkg::DIV_W-1:0]     divisor,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  gsc_pkg::num_t                 in_num,
	output logic                          out_valid,
	input  logic                          out_ready,
	output gsc_pkg::quo_t                 out_quo
);

	localparam int N = gsc_pkg::DIV_STAGES;
	localparam int BPS = gsc_pkg::BITS_PER_STAGE;
	localparam int QW = gsc_pkg::QUO_W;
	localparam int DW = gsc_pkg::DIV_W;
	localparam int HI_W = gsc_pkg::MAG_W - QW;

	logic [N-1:0]  v_s, adv, neg_s, ovf_s, neg_n, ovf_n;
	logic [DW-1:0] rem_s [N];
	logic [DW-1:0] rem_n [N];
	logic [QW-1:0] lo_s  [N];
	logic [QW-1:0] lo_n  [N];
	logic [QW-1:0] quo_s [N];
	logic [QW-1:0] quo_n [N];

	// One restoring step: shift in a dividend bit, subtract when it fits.
	function automatic logic [DW:0] div_step(input logic [DW-1:0] r, input logic b,
		input logic [DW-1:0] dv);
		logic [DW:0] t;
		logic        q;
		t = {r, b};
		q = (t >= {1'b0, dv});
		if (q) begin
			t = t - {1'b0, dv};
		end
		return {q, t[DW-1:0]};
	endfunction

	always_comb begin
		adv[N-1] = !v_s[N-1] || out_ready;
		for (int k = N - 2; k >= 0; k--) begin
			adv[k] = !v_s[k] || adv[k+1];
		end
	end
	assign in_ready = adv[0];

	always_comb begin
		logic [DW-1:0] r;
		logic [QW-1:0] lo, q;
		logic [DW:0]   st;
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				r        = DW'(in_num.mag[gsc_pkg::MAG_W-1:QW]);
				lo       = in_num.mag[QW-1:0];
				q        = '0;
				neg_n[k] = in_num.neg;
				ovf_n[k] = ({{(DW-HI_W){1'b0}}, in_num.mag[gsc_pkg::MAG_W-1:QW]}
					>= divisor);
			end else begin
				r        = rem_s[k-1];
				lo       = lo_s[k-1];
				q        = quo_s[k-1];
				neg_n[k] = neg_s[k-1];
				ovf_n[k] = ovf_s[k-1];
			end
			for (int j = 0; j < BPS; j++) begin
				st = div_step(r, lo[QW-1], divisor);
				r  = st[DW-1:0];
				q  = {q[QW-2:0], st[DW]};
				lo = {lo[QW-2:0], 1'b0};
			end
			rem_n[k] = r;
			lo_n[k]  = lo;
			quo_n[k] = q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int k = 0; k < N; k++) begin
				if (adv[k]) begin
					v_s[k] <= (k == 0) ? in_valid : v_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			if (adv[k]) begin
				rem_s[k] <= rem_n[k];
				lo_s[k]  <= lo_n[k];
				quo_s[k] <= quo_n[k];
				neg_s[k] <= neg_n[k];
				ovf_s[k] <= ovf_n[k];
			end
		end
	end

	assign out_valid   = v_s[N-1];
	assign out_quo.neg = neg_s[N-1];
	assign out_quo.ovf = ovf_s[N-1];
	assign out_quo.quo = quo_s[N-1];

endmodule

>>> rtl/gsc_checker.sv
// ----------------------------------------------------------------------------
// gsc_checker: port-level checks of the gas sensor compensation block
// Watches the stream and status ports and is bound to the top level.
// ----------------------------------------------------------------------------
module gsc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [gsc_pkg::PPB_W-1:0]     m_axis_tdata,
	input logic [gsc_pkg::STATUS_W-1:0]  m_axis_tuser
);

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// Input is taken whenever the output side can move.
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
		else $error("input stalled while output free");

	a_nosens_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == gsc_pkg::STATUS_NOSENS |->
			m_axis_tdata == '0)
		else $error("zero sensitivity result not zero");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == gsc_pkg::STATUS_SAT |->
			m_axis_tdata == 24'h7FFFFF || m_axis_tdata == 24'h800000)
		else $error("saturated result not at a limit");

endmodule

bind gas_sensor_temp_compensated_ppb gsc_checker u_gsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

>>> dv/gas_sensor_temp_compensated_ppb_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_sensor_temp_compensated_ppb_tb: self-checking bench for the ppb block
// Drives electrode voltages and temperatures through the input stream,
// programs the offset and sensitivity registers between phases, and checks
// every concentration and status against a cycle-free prediction of the
// same integer arithmetic. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module gas_sensor_temp_compensated_ppb_tb;
	import gsc_pkg::*;

	// Cycles from an input transaction to its result, plus margin for the
	// output register and a stalled receiver.
	localparam int PIPE_LATENCY = 20;
	localparam longint PPB_MAX = 8388607;
	localparam longint PPB_MIN = -8388608;
	// Index beyond the register map; a write there must change nothing.
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

	// One input item, packed exactly as s_axis_tdata[57:0].
	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic [VOLT_W-1:0]        aux;
		logic [VOLT_W-1:0]        worker;
	} sample_t;

	typedef struct packed {
		logic [PPB_W-1:0] ppb;
		status_t          status;
	} reading_t;

	// Register image as seen by software.
	typedef struct {
		logic                     fsel;
		logic signed [15:0]       wez;
		logic signed [15:0]       aez;
		logic signed [15:0]       wtz;
		logic signed [15:0]       atz;
		logic [SENS_W-1:0]        sens;
	} settings_t;

	// Compensation curves in tenths, points at -30..50 C in 10 C steps.
	int curve_one [9] = '{13, 13, 13, 13, 10, 6, 4, 2, -15};
	int curve_three [9] = '{10, 10, 10, 10, 10, 10, 4, -1, -40};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [63:0]            s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [PPB_W-1:0]       m_axis_tdata;
	logic [STATUS_W-1:0]    m_axis_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	settings_t  regs_now;
	reading_t   pending_readings [$];
	bit         tx_gaps_on = 1'b0;
	bit         rx_stalls_on = 1'b0;
	int         holdoff_request = 0;
	int         n_sent = 0;
	int         n_checked = 0;
	int         n_errors = 0;
	int         n_saturated = 0;
	int         n_nosens = 0;
	int         n_phases = 0;

	gas_sensor_temp_compensated_ppb dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial forever #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	function automatic int curve_tenths(logic sel, int idx);
		return sel ? curve_three[idx] : curve_one[idx];
	endfunction

	// Interpolated factor in thousandths; flat outside -30.0 .. 50.0 C.
	function automatic longint comp_thousandths(logic sel, int t);
		int off;
		int seg;
		int d;
		if (t <= -300)
			return 100 * curve_tenths(sel, 0);
		if (t >= 500)
			return 100 * curve_tenths(sel, 8);
		off = t + 300;
		seg = off / 100;
		d = off - 100 * seg;
		return 100 * curve_tenths(sel, seg)
			+ d * (curve_tenths(sel, seg + 1) - curve_tenths(sel, seg));
	endfunction

	function automatic reading_t predict_reading(sample_t smp);
		longint a;
		longint b;
		longint num;
		longint q;
		reading_t r;
		r.ppb = '0;
		r.status = STATUS_OK;
		if (regs_now.sens == 0) begin
			r.status = STATUS_NOSENS;
			return r;
		end
		a = longint'(smp.worker) - 1000 * longint'(regs_now.wez);
		b = longint'(smp.aux) - 1000 * longint'(regs_now.aez);
		// Formula three also removes the difference of the total zeros.
		if (regs_now.fsel)
			a -= 1000 * ((longint'(regs_now.wtz) - longint'(regs_now.wez))
				- (longint'(regs_now.atz) - longint'(regs_now.aez)));
		num = 1000 * a - comp_thousandths(regs_now.fsel, int'(smp.temp)) * b;
		q = num / (1000 * longint'(regs_now.sens));
		if (q > PPB_MAX) begin
			q = PPB_MAX;
			r.status = STATUS_SAT;
		end else if (q < PPB_MIN) begin
			q = PPB_MIN;
			r.status = STATUS_SAT;
		end
		r.ppb = q[PPB_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stream and register drivers
	// ------------------------------------------------------------------
	// Leave tvalid high on return so a following item can go out back to back.
	task automatic send_sample(sample_t smp);
		int gap;
		gap = tx_gaps_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, smp};
		do @(posedge clk); while (!s_axis_tready);
		pending_readings.push_back(predict_reading(smp));
		n_sent++;
	endtask

	// Drop tvalid, wait out every expected reading, then let the pipe empty.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	// Leave cfg_valid high on return; close_writes drops it.
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (cfg_reg_t'(idx))
			CFG_FORMULA_SELECT: regs_now.fsel = val[0];
			CFG_WORKER_EZERO:   regs_now.wez = val;
			CFG_AUX_EZERO:      regs_now.aez = val;
			CFG_WORKER_TZERO:   regs_now.wtz = val;
			CFG_AUX_TZERO:      regs_now.atz = val;
			CFG_SENSITIVITY:    regs_now.sens = val[SENS_W-1:0];
			default: ;
		endcase
	endtask

	// The scaled copy inside the block follows a write in the next cycle.
	task automatic close_writes();
		cfg_valid <= 1'b0;
		repeat (2) @(posedge clk);
	endtask

	task automatic apply_settings(settings_t s);
		wait_idle();
		write_reg(CFG_FORMULA_SELECT, {15'd0, s.fsel});
		write_reg(CFG_WORKER_EZERO, s.wez);
		write_reg(CFG_AUX_EZERO, s.aez);
		write_reg(CFG_WORKER_TZERO, s.wtz);
		write_reg(CFG_AUX_TZERO, s.atz);
		write_reg(CFG_SENSITIVITY, {1'b0, s.sens});
		close_writes();
		n_phases++;
	endtask

	task automatic pick_idling();
		case ($urandom_range(0, 3))
			0: begin
				tx_gaps_on = 1'b0;
				rx_stalls_on = 1'b0;
			end
			1: begin
				tx_gaps_on = 1'b1;
				rx_stalls_on = 1'b0;
			end
			2: begin
				tx_gaps_on = 1'b0;
				rx_stalls_on = 1'b1;
			end
			default: begin
				tx_gaps_on = 1'b1;
				rx_stalls_on = 1'b1;
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Random content
	// ------------------------------------------------------------------
	// Mostly in the rated 0..5 V span, sometimes the full 23-bit field.
	function automatic logic [VOLT_W-1:0] rand_volts();
		case ($urandom_range(0, 9))
			0: return VOLT_W'($urandom);
			1: return $urandom_range(0, 1) ? VOLT_W'(5000000) : '0;
			default: return VOLT_W'($urandom_range(0, 5000000));
		endcase
	endfunction

	// Mostly -100.0 .. 150.0 C, some at or next to table points, some any code.
	function automatic logic signed [TEMP_W-1:0] rand_temp();
		case ($urandom_range(0, 9))
			0: return TEMP_W'($urandom);
			1: return TEMP_W'(100 * $urandom_range(0, 8) + $urandom_range(0, 2) - 301);
			default: return TEMP_W'($urandom_range(0, 2500) - 1000);
		endcase
	endfunction

	function automatic sample_t rand_sample();
		sample_t smp;
		smp.worker = rand_volts();
		smp.aux = rand_volts();
		smp.temp = rand_temp();
		return smp;
	endfunction

	function automatic logic signed [15:0] rand_zero();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			3, 4: return 16'($urandom);
			default: return 16'($urandom_range(0, 800) - 400);
		endcase
	endfunction

	function automatic settings_t rand_settings();
		settings_t s;
		s.fsel = 1'($urandom_range(0, 1));
		s.wez = rand_zero();
		s.aez = rand_zero();
		s.wtz = rand_zero();
		s.atz = rand_zero();
		case ($urandom_range(0, 11))
			0: s.sens = '0;
			1: s.sens = 15'd1;
			2: s.sens = 15'h7fff;
			3: s.sens = SENS_W'($urandom);
			default: s.sens = SENS_W'($urandom_range(1, 400));
		endcase
		return s;
	endfunction

	function automatic settings_t fixed_settings(logic fsel, logic signed [15:0] wez,
		logic signed [15:0] aez, logic signed [15:0] wtz, logic signed [15:0] atz,
		logic [SENS_W-1:0] sens);
		settings_t s;
		s.fsel = fsel;
		s.wez = wez;
		s.aez = aez;
		s.wtz = wtz;
		s.atz = atz;
		s.sens = sens;
		return s;
	endfunction

	function automatic sample_t make_sample(int worker, int aux, int temp);
		sample_t smp;
		smp.worker = VOLT_W'(worker);
		smp.aux = VOLT_W'(aux);
		smp.temp = TEMP_W'(temp);
		return smp;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	task automatic check_reading(logic [PPB_W-1:0] ppb, logic [STATUS_W-1:0] status);
		reading_t want;
		if (pending_readings.size() == 0) begin
			$display("%0t ns: result with nothing expected: ppb %0d status %0d",
				$time, $signed(ppb), status);
			n_errors++;
			return;
		end
		want = pending_readings.pop_front();
		if (ppb !== want.ppb) begin
			$display("%0t ns: concentration_ppb mismatch: expected %0d, actual %0d",
				$time, $signed(want.ppb), $signed(ppb));
			n_errors++;
		end
		if (status !== want.status) begin
			$display("%0t ns: result_status mismatch: expected %0d, actual %0d",
				$time, want.status, status);
			n_errors++;
		end
		if (want.status == STATUS_SAT)
			n_saturated++;
		if (want.status == STATUS_NOSENS)
			n_nosens++;
		n_checked++;
	endtask

	// Result side: random stalls per transaction, plus a long hold-off on
	// request, counted here so the sender keeps pushing meanwhile.
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (holdoff_request > 0) begin
				m_axis_tready <= 1'b0;
				repeat (holdoff_request) @(posedge clk);
				holdoff_request = 0;
			end
			stall = rx_stalls_on ? $urandom_range(0, 3) : 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			check_reading(m_axis_tdata, m_axis_tuser);
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Out of reset the sensitivity is zero: every item reports the error.
	task automatic test_unconfigured();
		regs_now = fixed_settings(1'b1, '0, '0, '0, '0, '0);
		send_sample(make_sample(0, 0, -2048));
		send_sample(make_sample(8388607, 8388607, 2047));
		wait_idle();
	endtask

	// Curve three at the clamp edges, around them and at the ends of the
	// temperature field; curve one at both clamp edges and between them.
	task automatic test_table_edges();
		int curve_three_temps [8] = '{-2048, -301, -300, -299, 0, 499, 500, 2047};
		int curve_one_temps [5] = '{-300, 150, 450, 499, 500};
		apply_settings(fixed_settings(1'b1, '0, '0, '0, '0, 15'd1));
		foreach (curve_three_temps[i])
			send_sample(make_sample(5000000 - 600000 * i, 1234567 + 400000 * i,
				curve_three_temps[i]));
		apply_settings(fixed_settings(1'b0, '0, '0, '0, '0, 15'd1));
		foreach (curve_one_temps[i])
			send_sample(make_sample(300000 * i, 4999999 - 700000 * i, curve_one_temps[i]));
		wait_idle();
	endtask

	// Offsets at their extremes drive quotients past the negative rail; a write
	// to an unmapped index must leave the results alone.
	task automatic test_offsets_saturation();
		apply_settings(fixed_settings(1'b1, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
			15'd1));
		write_reg(CFG_UNUSED_INDEX, 16'($urandom));
		close_writes();
		send_sample(make_sample(8388607, 0, 500));
		send_sample(make_sample(0, 8388607, -300));
		apply_settings(fixed_settings(1'b0, 16'sh7fff, 16'sh8000, '0, '0, 15'd1));
		send_sample(make_sample(0, 5000000, 100));
		apply_settings(fixed_settings(1'b0, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
			15'h7fff));
		send_sample(make_sample(5000000, 0, 250));
		send_sample(make_sample(2500000, 2500000, -1000));
		wait_idle();
	endtask

	// Many register settings, the two extreme ones first.
	task automatic test_random_settings();
		settings_t s;
		for (int phase = 0; phase < 12; phase++) begin
			if (phase == 0)
				s = fixed_settings(1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 15'h7fff);
			else if (phase == 1)
				s = fixed_settings(1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 15'd1);
			else
				s = rand_settings();
			apply_settings(s);
			pick_idling();
			repeat (140) send_sample(rand_sample());
		end
		wait_idle();
	endtask

	// Hold the result side off long enough that the pipe fills and the
	// input stalls, while items keep coming.
	task automatic test_output_holdoff();
		settings_t s;
		s = rand_settings();
		if (s.sens == 0)
			s.sens = 15'd50;
		apply_settings(s);
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		holdoff_request = 60;
		repeat (120) send_sample(rand_sample());
		wait_idle();
	endtask

	// Short bursts, each drained completely before the next one starts.
	task automatic test_sender_pause();
		apply_settings(rand_settings());
		for (int burst = 0; burst < 5; burst++) begin
			pick_idling();
			repeat (30) send_sample(rand_sample());
			wait_idle();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unconfigured();
		test_table_edges();
		test_offsets_saturation();
		test_random_settings();
		test_output_holdoff();
		test_sender_pause();
		wait_idle();
		$display("Covered %0d items over %0d register settings, %0d results checked,",
			n_sent, n_phases, n_checked);
		$display("of them %0d saturated and %0d with zero sensitivity; %0d mismatches.",
			n_saturated, n_nosens, n_errors);
		if (n_errors == 0 && pending_readings.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> files.f
rtl/gsc_pkg.sv
rtl/gsc_cfg_regs.sv
rtl/gsc_front.sv
rtl/gsc_div.sv
rtl/gas_sensor_temp_compensated_ppb.sv
rtl/gsc_checker.sv
dv/gas_sensor_temp_compensated_ppb_tb.sv
